// ----- design/plc_pkg.sv -----
// Shared types and constants for the plain-changes permuter.
package plc_pkg;

   // Field widths of the channels and the length register
   localparam int LEN_W  = 5;
   localparam int IDX_W  = 4;
   localparam int BYTE_W = 8;

   // Operation codes of an input item
   typedef enum logic [0:0] {
      OP_LOAD    = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   // Direction of an element in the arrangement
   localparam logic DIR_LEFT  = 1'b0;
   localparam logic DIR_RIGHT = 1'b1;

endpackage

// ----- design/plc_req_if.sv -----
// Input channel: load or advance items with valid/ready handshake.
interface plc_req_if;
   logic                        valid;
   logic                        ready;
   plc_pkg::op_type             operation;
   logic [plc_pkg::IDX_W-1:0]   index;
   logic [plc_pkg::BYTE_W-1:0]  byte_value;

   modport source (output valid, output operation, output index, output byte_value,
                   input ready);
   modport sink   (input valid, input operation, input index, input byte_value,
                   output ready);
endinterface

// ----- design/plc_rsp_if.sv -----
// Result channel: one buffer byte per item with valid/ready handshake.
interface plc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [plc_pkg::IDX_W-1:0]   position;
   logic [plc_pkg::BYTE_W-1:0]  byte_out;
   logic                        last;
   logic                        cycle_restarted;

   modport source (output valid, output position, output byte_out, output last,
                   output cycle_restarted, input ready);
   modport sink   (input valid, input position, input byte_out, input last,
                   input cycle_restarted, output ready);
endinterface

// ----- design/plain_changes_permuter.sv -----
// Plain-changes permutation generator over a byte buffer (top level).
//
// Channels: req_chan takes items; a load (operation 0) writes one buffer byte
// and restarts the generator, an advance (operation 1) steps to the next
// plain-changes arrangement, swaps the matching pair of buffer bytes and then
// emits the whole buffer on rsp_chan, one item per byte, last byte flagged.
// csr_wr_en/csr_wr_data write the length (saturated to MAX_LENGTH) and also
// restart the generator; write it only while the block is idle.
// Sequence: an advance starts, then for each element the scan visits it does
// the position/direction read, the neighbor read and the compare; then the
// swap on stores with one write port each, a read to prime the buffer, and
// then one emitted byte per cycle while rsp_chan does not stall. Length 1
// skips the scan and the swap; length 0 returns to idle with no output.
// Only one item is worked on at a time: req_chan.ready is high in idle.
// A stalled rsp_chan holds the byte in the output register and pauses the
// emit sweep; the next item can be accepted while the last byte waits.
// Reset: synchronous; length becomes 0 and the tables read as the start
// arrangement at once (per-entry valid bits, no clearing pass). Buffer bytes
// are undefined until loaded.
module plain_changes_permuter #(
   parameter int MAX_LENGTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [plc_pkg::LEN_W-1:0]  csr_wr_data,
   plc_req_if.sink                    req_chan,
   plc_rsp_if.source                  rsp_chan
);

   localparam int SLOTS       = MAX_LENGTH + 2;
   localparam int EW          = $clog2(SLOTS);
   localparam int STORE_DEPTH = (MAX_LENGTH < 16) ? MAX_LENGTH : 16;
   localparam int DW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_NB,
      ST_SCAN_CMP,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_SWAP_C,
      ST_SWAP_D,
      ST_EMIT_RD,
      ST_EMIT
   } state_type;

   // Control and working registers
   state_type                   state_ff, state_in;
   logic [EW-1:0]               len_ff, len_in;
   logic [EW-1:0]               mobile_ff, mobile_in;
   logic [EW-1:0]               m_ff, m_in;
   logic [EW-1:0]               from_ff, from_in;
   logic [EW-1:0]               to_ff, to_in;
   logic                        dir_ff, dir_in;
   logic [EW-1:0]               other_ff, other_in;
   logic [plc_pkg::BYTE_W-1:0]  byte_a_ff, byte_a_in;
   logic [EW-1:0]               k_ff, k_in;
   logic                        restarted_ff, restarted_in;

   // Output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [plc_pkg::IDX_W-1:0]   rsp_position_ff, rsp_position_in;
   logic [plc_pkg::BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_restart_ff, rsp_restart_in;

   // Arrangement store
   logic [EW-1:0]               arr_ff [SLOTS];
   logic [SLOTS-1:0]            arr_vld_ff;
   logic                        arr_we;
   logic [EW-1:0]               arr_wa, arr_wd, arr_ra;
   logic [EW-1:0]               arr_rd_ff, arr_ra_ff;
   logic                        arr_rv_ff;

   // Element position store
   logic [EW-1:0]               pos_ff [SLOTS];
   logic [SLOTS-1:0]            pos_vld_ff;
   logic                        pos_we;
   logic [EW-1:0]               pos_wa, pos_wd;
   logic [EW-1:0]               pos_rd_ff, pos_ra_ff;
   logic                        pos_rv_ff;

   // Direction store
   logic                        dirm_ff [SLOTS];
   logic [SLOTS-1:0]            dir_vld_ff;
   logic                        dir_we;
   logic                        dir_rd_ff;
   logic                        dir_rv_ff;

   // Buffer store
   logic [plc_pkg::BYTE_W-1:0]  data_ff [STORE_DEPTH];
   logic                        data_we;
   logic [DW-1:0]               data_wa, data_ra;
   logic [plc_pkg::BYTE_W-1:0]  data_wd, data_rd_ff;

   // Misc combinational
   logic                        accept, restart, out_free, swap_ok;
   logic [EW-1:0]               len_sat, len_new;
   logic [EW-1:0]               pos_val, arr_val, nb;
   logic                        dir_val;
   logic [EW-1:0]               m_dec, oth_dec, k_inc;
   logic [EW+3:0]               k_ext;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.position        = rsp_position_ff;
   assign rsp_chan.byte_out        = rsp_byte_ff;
   assign rsp_chan.last            = rsp_last_ff;
   assign rsp_chan.cycle_restarted = rsp_restart_ff;

   // Length write saturates at MAX_LENGTH
   assign len_sat = (int'(csr_wr_data) > MAX_LENGTH) ? EW'(MAX_LENGTH) : EW'(csr_wr_data);
   assign len_new = csr_wr_en ? len_sat : len_ff;

   // Store reads: entries not written since restart read as the start values
   assign pos_val = pos_rv_ff ? pos_rd_ff : pos_ra_ff;
   assign dir_val = dir_rv_ff ? dir_rd_ff : plc_pkg::DIR_LEFT;
   assign arr_val = arr_rv_ff ? arr_rd_ff :
                    ((arr_ra_ff == '0) ? (len_ff + EW'(1)) : arr_ra_ff);
   assign nb      = (dir_val == plc_pkg::DIR_RIGHT) ? (pos_val + EW'(1)) : (pos_val - EW'(1));

   assign m_dec   = m_ff - EW'(1);
   assign oth_dec = other_ff - EW'(1);
   assign k_inc   = k_ff + EW'(1);
   assign k_ext   = {4'b0000, k_ff};
   assign swap_ok = (m_ff <= EW'(STORE_DEPTH)) && (other_ff <= EW'(STORE_DEPTH));
   assign arr_ra  = nb;

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      len_in          = len_new;
      mobile_in       = mobile_ff;
      m_in            = m_ff;
      from_in         = from_ff;
      to_in           = to_ff;
      dir_in          = dir_ff;
      other_in        = other_ff;
      byte_a_in       = byte_a_ff;
      k_in            = k_ff;
      restarted_in    = restarted_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_position_in = rsp_position_ff;
      rsp_byte_in     = rsp_byte_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_restart_in  = rsp_restart_ff;
      restart         = csr_wr_en;
      arr_we          = 1'b0;
      arr_wa          = to_ff;
      arr_wd          = m_ff;
      pos_we          = 1'b0;
      pos_wa          = m_ff;
      pos_wd          = to_ff;
      dir_we          = 1'b0;
      data_we         = 1'b0;
      data_wa         = m_dec[DW-1:0];
      data_wd         = data_rd_ff;
      data_ra         = k_ff[DW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.operation == plc_pkg::OP_LOAD) begin
                  restart = 1'b1;
                  data_wa = req_chan.index[DW-1:0];
                  data_wd = req_chan.byte_value;
                  data_we = (int'(req_chan.index) < STORE_DEPTH);
               end else if (len_ff != '0) begin
                  restarted_in = (mobile_ff == EW'(1));
                  // a single byte never touches the tables; mobile just stays at 1
                  if ((mobile_ff == EW'(1)) && (len_ff != EW'(1))) begin
                     restart = 1'b1;
                  end
                  m_in = len_ff;
                  k_in = '0;
                  if (len_ff == EW'(1)) begin
                     mobile_in = EW'(1);
                     state_in  = ST_EMIT_RD;
                  end else begin
                     state_in = ST_SCAN_RD;
                  end
               end
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_NB;
         end
         ST_SCAN_NB: begin
            from_in  = pos_val;
            to_in    = nb;
            dir_in   = dir_val;
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (arr_val > m_ff) begin
               // blocked: turn around and try the next smaller element
               dir_we = 1'b1;
               m_in   = m_dec;
               if (m_ff == EW'(2)) begin
                  mobile_in = EW'(1);
                  state_in  = ST_EMIT_RD;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end else begin
               mobile_in = m_ff;
               other_in  = arr_val;
               state_in  = ST_SWAP_A;
            end
         end
         ST_SWAP_A: begin
            arr_we   = 1'b1;
            pos_we   = 1'b1;
            data_ra  = m_dec[DW-1:0];
            state_in = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            arr_we    = 1'b1;
            arr_wa    = from_ff;
            arr_wd    = other_ff;
            pos_we    = 1'b1;
            pos_wa    = other_ff;
            pos_wd    = from_ff;
            data_ra   = oth_dec[DW-1:0];
            byte_a_in = data_rd_ff;
            state_in  = ST_SWAP_C;
         end
         ST_SWAP_C: begin
            data_we  = swap_ok;
            state_in = ST_SWAP_D;
         end
         ST_SWAP_D: begin
            data_we  = swap_ok;
            data_wa  = oth_dec[DW-1:0];
            data_wd  = byte_a_ff;
            state_in = ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_position_in = k_ext[plc_pkg::IDX_W-1:0];
               rsp_byte_in     = (k_ff < EW'(STORE_DEPTH)) ? data_rd_ff : '0;
               rsp_last_in     = (k_ff == (len_ff - EW'(1)));
               rsp_restart_in  = restarted_ff;
               if (k_ff == (len_ff - EW'(1))) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in    = k_inc;
                  data_ra = k_inc[DW-1:0];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (restart) begin
         mobile_in = len_new + EW'(1);
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         mobile_ff    <= EW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         mobile_ff    <= mobile_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      m_ff            <= m_in;
      from_ff         <= from_in;
      to_ff           <= to_in;
      dir_ff          <= dir_in;
      other_ff        <= other_in;
      byte_a_ff       <= byte_a_in;
      k_ff            <= k_in;
      restarted_ff    <= restarted_in;
      rsp_position_ff <= rsp_position_in;
      rsp_byte_ff     <= rsp_byte_in;
      rsp_last_ff     <= rsp_last_in;
      rsp_restart_ff  <= rsp_restart_in;
   end

   // Valid bits: cleared by restart, so the tables fall back to the start arrangement
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         arr_vld_ff <= '0;
         pos_vld_ff <= '0;
         dir_vld_ff <= '0;
      end else begin
         if (arr_we) begin
            arr_vld_ff[arr_wa] <= 1'b1;
         end
         if (pos_we) begin
            pos_vld_ff[pos_wa] <= 1'b1;
         end
         if (dir_we) begin
            dir_vld_ff[m_ff] <= 1'b1;
         end
      end
   end

   // Arrangement store, registered read
   always_ff @(posedge clock) begin
      if (arr_we) begin
         arr_ff[arr_wa] <= arr_wd;
      end
      arr_rd_ff <= arr_ff[arr_ra];
      arr_ra_ff <= arr_ra;
      arr_rv_ff <= arr_vld_ff[arr_ra];
   end

   // Position and direction stores, both read at the scanned element
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_ff[pos_wa] <= pos_wd;
      end
      if (dir_we) begin
         dirm_ff[m_ff] <= ~dir_ff;
      end
      pos_rd_ff <= pos_ff[m_ff];
      pos_ra_ff <= m_ff;
      pos_rv_ff <= pos_vld_ff[m_ff];
      dir_rd_ff <= dirm_ff[m_ff];
      dir_rv_ff <= dir_vld_ff[m_ff];
   end

   // Buffer store, registered read
   always_ff @(posedge clock) begin
      if (data_we) begin
         data_ff[data_wa] <= data_wd;
      end
      data_rd_ff <= data_ff[data_ra];
   end

endmodule
